// ===== rtl/bap_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bap_pkg
// shared types, widths and codes of the burst-averaged priority scheduler
// ----------------------------------------------------------------------------
package bap_pkg;

    localparam int SLOTS   = 64;
    localparam int QUEUES  = 16;

    localparam int FUNC_W  = 3;
    localparam int SLOT_W  = 6;
    localparam int REQ_W   = 8;
    localparam int QNT_W   = 16;
    localparam int IPC_W   = 16;
    localparam int ST_W    = 2;
    localparam int PRIO_W  = 4;
    localparam int SLICE_W = 18;
    localparam int BASE_W  = 16;
    localparam int BURST_W = 22;

    // shared divider: dividend covers slice * 10 and the ring sum
    localparam int DIV_DW  = 28;
    localparam int DIV_VW  = IPC_W + 1;

    localparam logic [SLICE_W-1:0] SLICE_MAX = 18'h3FFFF;
    localparam logic [BASE_W-1:0]  BASE_MAX  = 16'hFFFF;

    localparam int K_SCALE = 1000;
    localparam int K_PCT   = 100;
    localparam int K_TEN   = 10;

    // x / 10 as (x * 52429) >> 19, exact for any 16-bit x
    localparam int K_RECIP10    = 52429;
    localparam int K_RECIP10_SH = 19;

    localparam logic [FUNC_W-1:0] FN_START   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INHERIT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_OOQ     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_NICE    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_STOP    = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_NOUSE = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_BUSY  = 2'd3;

    typedef struct packed {
        logic [PRIO_W-1:0]  max_prio;
        logic [PRIO_W-1:0]  cur_prio;
        logic [SLICE_W-1:0] cur_slice;
        logic [BASE_W-1:0]  base_slice;
    } t_slot_ent;

endpackage
`default_nettype wire

// ===== rtl/burst_averaged_priority_scheduler_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// burst_averaged_priority_scheduler_top
// process slot table with burst-averaged priority and slice adjustment
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  request   in         i_valid / o_ready      func, slot, parent_slot, priority,
//                                              quantum, ipc counts
//  result    out        o_valid / i_ready      status, new_priority, new_time_slice
//  config    in         i_cfg_we               i_cfg_wdata (lowest user queue)
//
// start, inherit, nice, stop and bad func codes: result passes through slot table
// read, evaluate and write back, then output load
// out of quantum: result takes two passes through the shared 28-bit divider
// (slice * 10 / ipc, then ring sum / (fill * 10)) plus one read per ring
// entry for the sum
// one item at a time: o_ready is high only while the sequencer is idle; a
// result still waiting at the output holds the next item in its last state
// synchronous active-low reset clears the in-use flags and the control state;
// the slot table and the burst ring need no clearing pass
// ----------------------------------------------------------------------------
module burst_averaged_priority_scheduler_top #(
    parameter int HISTORY = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [bap_pkg::PRIO_W-1:0]  i_cfg_wdata,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [bap_pkg::FUNC_W-1:0]  i_func,
    input  wire logic [bap_pkg::SLOT_W-1:0]  i_slot,
    input  wire logic [bap_pkg::SLOT_W-1:0]  i_parent_slot,
    input  wire logic [bap_pkg::REQ_W-1:0]   i_requested_priority,
    input  wire logic [bap_pkg::QNT_W-1:0]   i_quantum,
    input  wire logic [bap_pkg::IPC_W-1:0]   i_ipc_async,
    input  wire logic [bap_pkg::IPC_W-1:0]   i_ipc_sync,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic      [bap_pkg::ST_W-1:0]    o_status,
    output logic      [bap_pkg::PRIO_W-1:0]  o_new_priority,
    output logic      [bap_pkg::SLICE_W-1:0] o_new_time_slice
);
    import bap_pkg::*;

    localparam int PW   = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int FW   = $clog2(HISTORY + 1);
    localparam int RAW  = $clog2(SLOTS * HISTORY);
    localparam int EW   = $bits(t_slot_ent);
    localparam int SRW  = EW + FW + PW;
    localparam int NSW  = 22;
    localparam int RPW  = 2 * BASE_W;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RD   = 10'b0000000010,
        S_EVAL = 10'b0000000100,
        S_MUL  = 10'b0000001000,
        S_DIV1 = 10'b0000010000,
        S_SUM  = 10'b0000100000,
        S_SUMW = 10'b0001000000,
        S_DIV2 = 10'b0010000000,
        S_FIN  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [PRIO_W-1:0] r_luq;

    // latched item
    logic [FUNC_W-1:0] r_func;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_parent;
    logic [REQ_W-1:0]  r_req;
    logic [QNT_W-1:0]  r_quantum;
    logic [DIV_VW-1:0] r_ipc;
    logic [SLOT_W-1:0] r_rd_addr;

    logic [SLOTS-1:0]  r_in_use;

    // out of quantum working set
    t_slot_ent         r_ent;
    logic [FW-1:0]     r_fill;
    logic [PW-1:0]     r_ptr;
    logic [DIV_DW-1:0] r_prod;
    logic [DIV_DW-1:0] r_q;
    logic [DIV_DW-1:0] r_acc;
    logic [FW-1:0]     r_idx;
    logic              r_rv;
    logic [PRIO_W-1:0] r_bump;
    logic              r_div_go, n_div_go;

    // result being built and output register
    logic [ST_W-1:0]    r_st;
    logic [PRIO_W-1:0]  r_np;
    logic [SLICE_W-1:0] r_ns;
    logic               r_o_valid;
    logic [ST_W-1:0]    r_o_status;
    logic [PRIO_W-1:0]  r_o_prio;
    logic [SLICE_W-1:0] r_o_slice;

    // slot table
    logic              sr_we;
    logic [SRW-1:0]    sr_wdata;
    logic [SRW-1:0]    sr_rdata;
    t_slot_ent         rd_ent;
    logic [FW-1:0]     rd_fill;
    logic [PW-1:0]     rd_ptr;

    // burst ring
    logic               rr_we;
    logic [RAW-1:0]     ring_base;
    logic [RAW-1:0]     rr_waddr;
    logic [RAW-1:0]     rr_raddr;
    logic [BURST_W-1:0] rr_rdata;

    // shared divider
    logic [DIV_DW-1:0] dv_dividend;
    logic [DIV_VW-1:0] dv_divisor;
    logic              dv_done;
    logic [DIV_DW-1:0] dv_quot;

    // base / 10 by reciprocal
    logic [RPW-1:0]    b10_prod;

    // evaluate step
    logic [ST_W-1:0]    ev_st;
    logic [PRIO_W-1:0]  ev_prio;
    logic [SLICE_W-1:0] ev_slice;
    logic               ev_we;
    logic               ev_set;
    logic               ev_clr;
    logic               ev_ooq;
    t_slot_ent          ev_ent;
    logic [FW-1:0]      ev_fill;
    logic [PW-1:0]      ev_ptr;

    // bump clamp and final slice
    logic [DIV_DW:0]    cl_sum;
    logic [PRIO_W-1:0]  cl_bump;
    logic [NSW-1:0]     fin_ns;
    t_slot_ent          fin_ent;

    assign rd_ent  = t_slot_ent'(sr_rdata[SRW-1 -: EW]);
    assign rd_fill = sr_rdata[PW +: FW];
    assign rd_ptr  = sr_rdata[PW-1:0];

    assign ring_base = RAW'(r_slot) * RAW'(HISTORY);
    assign rr_waddr  = ring_base + RAW'(r_ptr);
    assign rr_raddr  = ring_base + RAW'(r_idx[PW-1:0]);
    // the burst is written the cycle the first division finishes
    assign rr_we     = (r_state == S_DIV1) && dv_done;

    assign b10_prod = RPW'(r_ent.base_slice) * RPW'(K_RECIP10);

    bap_ram #(
        .WIDTH (SRW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (sr_we),
        .i_waddr (r_slot),
        .i_wdata (sr_wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (sr_rdata)
    );

    bap_ram #(
        .WIDTH (BURST_W),
        .DEPTH (SLOTS * HISTORY)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (rr_we),
        .i_waddr (rr_waddr),
        .i_wdata (dv_quot[BURST_W-1:0]),
        .i_raddr (rr_raddr),
        .o_rdata (rr_rdata)
    );

    bap_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (dv_dividend),
        .i_divisor  (dv_divisor),
        .o_done     (dv_done),
        .o_quot     (dv_quot)
    );

    // divider operands follow the step in progress
    // burst = (slice * 1000 / ipc) / 100 = slice * 10 / ipc
    // bump  = (sum / fill) / 10 = sum / (fill * 10)
    always_comb begin
        dv_dividend = r_prod;
        dv_divisor  = r_ipc;
        case (r_state)
            S_DIV2: begin
                dv_dividend = r_acc;
                dv_divisor  = DIV_VW'(r_fill) * DIV_VW'(K_TEN);
            end
            default: ;
        endcase
    end

    // decide start, inherit, nice, stop; out of quantum continues below
    always_comb begin
        ev_st    = ST_OK;
        ev_prio  = '0;
        ev_slice = '0;
        ev_we    = 1'b0;
        ev_set   = 1'b0;
        ev_clr   = 1'b0;
        ev_ooq   = 1'b0;
        ev_ent   = rd_ent;
        ev_fill  = rd_fill;
        ev_ptr   = rd_ptr;
        case (r_func)
            FN_START, FN_INHERIT: begin
                if (r_in_use[r_slot]) begin
                    ev_st = ST_BUSY;
                end else if (r_req >= REQ_W'(QUEUES)) begin
                    ev_st = ST_RANGE;
                end else if (r_func == FN_INHERIT && !r_in_use[r_parent]) begin
                    ev_st = ST_NOUSE;
                end else begin
                    ev_we           = 1'b1;
                    ev_set          = 1'b1;
                    ev_fill         = '0;
                    ev_ptr          = '0;
                    ev_ent.max_prio = r_req[PRIO_W-1:0];
                    if (r_func == FN_START) begin
                        ev_ent.cur_prio   = r_req[PRIO_W-1:0];
                        ev_ent.cur_slice  = SLICE_W'(r_quantum);
                        ev_ent.base_slice = r_quantum;
                    end else begin
                        // parent entry was read; saturate the inherited base
                        ev_ent.base_slice = (rd_ent.cur_slice > SLICE_W'(BASE_MAX)) ?
                                            BASE_MAX : rd_ent.cur_slice[BASE_W-1:0];
                    end
                    ev_prio  = ev_ent.cur_prio;
                    ev_slice = ev_ent.cur_slice;
                end
            end
            FN_NICE: begin
                if (!r_in_use[r_slot]) begin
                    ev_st = ST_NOUSE;
                end else if (r_req >= REQ_W'(QUEUES)) begin
                    ev_st = ST_RANGE;
                end else begin
                    ev_we           = 1'b1;
                    ev_ent.max_prio = r_req[PRIO_W-1:0];
                    ev_ent.cur_prio = r_req[PRIO_W-1:0];
                    ev_prio         = r_req[PRIO_W-1:0];
                    ev_slice        = rd_ent.cur_slice;
                end
            end
            FN_OOQ: begin
                if (!r_in_use[r_slot]) begin
                    ev_st = ST_NOUSE;
                end else begin
                    ev_ooq = 1'b1;
                end
            end
            FN_STOP: begin
                if (!r_in_use[r_slot]) begin
                    ev_st = ST_NOUSE;
                end else begin
                    ev_clr = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // bump clamp against the lowest user queue
    always_comb begin
        cl_sum = (DIV_DW + 1)'(r_ent.max_prio) + (DIV_DW + 1)'(dv_quot);
        if (cl_sum > (DIV_DW + 1)'(r_luq)) begin
            cl_bump = (r_ent.max_prio > r_luq) ? '0 : r_luq - r_ent.max_prio;
        end else begin
            cl_bump = dv_quot[PRIO_W-1:0];
        end
    end

    // new slice = base + 2 * bump * (base / 10), saturated
    always_comb begin
        fin_ns = NSW'(r_ent.base_slice)
               + ((NSW'(r_bump) * NSW'(r_q[BASE_W-1:0])) << 1);
        fin_ent           = r_ent;
        fin_ent.cur_prio  = r_ent.max_prio + r_bump;
        fin_ent.cur_slice = (fin_ns > NSW'(SLICE_MAX)) ? SLICE_MAX : fin_ns[SLICE_W-1:0];
    end

    // slot table write port
    always_comb begin
        sr_we    = 1'b0;
        sr_wdata = {fin_ent, r_fill, r_ptr};
        if (r_state == S_EVAL) begin
            sr_we    = ev_we;
            sr_wdata = {ev_ent, ev_fill, ev_ptr};
        end else if (r_state == S_FIN) begin
            sr_we = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_div_go = 1'b0;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_RD;
            S_RD:   n_state = S_EVAL;
            S_EVAL: n_state = ev_ooq ? S_MUL : S_DONE;
            S_MUL: begin
                n_state  = S_DIV1;
                n_div_go = 1'b1;
            end
            S_DIV1: if (dv_done) n_state = S_SUM;
            S_SUM:  if (r_idx == r_fill - 1'b1) n_state = S_SUMW;
            S_SUMW: begin
                n_state  = S_DIV2;
                n_div_go = 1'b1;
            end
            S_DIV2: if (dv_done) n_state = S_FIN;
            S_FIN:  n_state = S_DONE;
            S_DONE: if (!r_o_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_luq     <= PRIO_W'(14);
            r_in_use  <= '0;
            r_div_go  <= 1'b0;
            r_rv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= n_div_go;
            r_rv     <= (r_state == S_SUM);

            if (i_cfg_we) begin
                r_luq <= i_cfg_wdata;
            end

            // taken result clears unless a new one is loaded below
            if (r_o_valid && i_ready && r_state != S_DONE) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_func    <= i_func;
                    r_slot    <= i_slot;
                    r_parent  <= i_parent_slot;
                    r_req     <= i_requested_priority;
                    r_quantum <= i_quantum;
                    r_ipc     <= DIV_VW'(i_ipc_async) + DIV_VW'(i_ipc_sync) + 1'b1;
                    // inherit reads the parent entry, everything else the slot
                    r_rd_addr <= (i_func == FN_INHERIT) ? i_parent_slot : i_slot;
                end
                S_EVAL: begin
                    r_st   <= ev_st;
                    r_np   <= ev_prio;
                    r_ns   <= ev_slice;
                    r_ent  <= rd_ent;
                    r_fill <= rd_fill;
                    r_ptr  <= rd_ptr;
                    if (ev_set) r_in_use[r_slot] <= 1'b1;
                    if (ev_clr) r_in_use[r_slot] <= 1'b0;
                end
                S_MUL: begin
                    r_prod <= DIV_DW'(r_ent.cur_slice) * DIV_DW'(K_TEN);
                    r_q    <= DIV_DW'(b10_prod[RPW-1:K_RECIP10_SH]);
                end
                S_DIV1: if (dv_done) begin
                    // burst goes into the ring at the write pointer
                    r_ptr <= (r_ptr == PW'(HISTORY - 1)) ? '0 : r_ptr + 1'b1;
                    if (r_fill < FW'(HISTORY)) r_fill <= r_fill + 1'b1;
                    r_idx <= '0;
                    r_acc <= '0;
                end
                S_SUM: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_rv) r_acc <= r_acc + DIV_DW'(rr_rdata);
                end
                S_SUMW: begin
                    if (r_rv) r_acc <= r_acc + DIV_DW'(rr_rdata);
                end
                S_DIV2: if (dv_done) r_bump <= cl_bump;
                S_FIN: begin
                    r_st <= ST_OK;
                    r_np <= fin_ent.cur_prio;
                    r_ns <= fin_ent.cur_slice;
                end
                S_DONE: if (!r_o_valid || i_ready) begin
                    r_o_valid  <= 1'b1;
                    r_o_status <= r_st;
                    r_o_prio   <= r_np;
                    r_o_slice  <= r_ns;
                end
                default: ;
            endcase
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_new_priority   = r_o_prio;
    assign o_new_time_slice = r_o_slice;
endmodule
`default_nettype wire

// ===== rtl/bap_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bap_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module bap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== rtl/bap_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bap_div
// shared radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bap_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bap_pkg::DIV_DW-1:0] i_dividend,
    input  wire logic [bap_pkg::DIV_VW-1:0] i_divisor,
    output logic                            o_done,
    output logic      [bap_pkg::DIV_DW-1:0] o_quot
);
    import bap_pkg::*;

    localparam int CW = $clog2(DIV_DW + 1);

    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_VW-1:0] r_rem;
    logic [DIV_VW-1:0] r_den;
    logic [DIV_DW-1:0] r_quo;
    logic [DIV_VW:0]   w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_quo[DIV_DW-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_DW);
                r_rem  <= '0;
                r_den  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= w_fit ? DIV_VW'(w_trial - {1'b0, r_den}) : w_trial[DIV_VW-1:0];
                r_quo <= {r_quo[DIV_DW-2:0], w_fit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule
`default_nettype wire

// ===== rtl/bap_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bap_chk
// port-level checks for the burst-averaged priority scheduler
// ----------------------------------------------------------------------------
module bap_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_valid,
    input wire logic                        o_ready,
    input wire logic                        o_valid,
    input wire logic                        i_ready,
    input wire logic [bap_pkg::ST_W-1:0]    o_status,
    input wire logic [bap_pkg::PRIO_W-1:0]  o_new_priority,
    input wire logic [bap_pkg::SLICE_W-1:0] o_new_time_slice
);
    import bap_pkg::*;

    // failed operations report zero priority and slice
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_new_priority == '0 && o_new_time_slice == '0)
        else $error("error result with nonzero payload");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after accept");

    // no result out of reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_new_priority) && $stable(o_new_time_slice))
        else $error("stalled result changed");
endmodule

bind burst_averaged_priority_scheduler_top bap_chk u_bap_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_status         (o_status),
    .o_new_priority   (o_new_priority),
    .o_new_time_slice (o_new_time_slice)
);
`default_nettype wire
